// ----- hdl/link_quality_acceptance_core_assert.svh -----
// assertion macros used by the checker file
// depends on signals named clock and reset in the using scope
`ifndef LINK_QUALITY_ACCEPTANCE_CORE_ASSERT_SVH
`define LINK_QUALITY_ACCEPTANCE_CORE_ASSERT_SVH

// checked at every edge, reset included
`define LQA_ASSERT_ALWAYS(label, prop, msg) \
   label: assert property (@(posedge clock) prop) else $error(msg);

// checked outside reset
`define LQA_ASSERT(label, prop, msg) \
   label: assert property (@(posedge clock) disable iff (reset) prop) else $error(msg);

`endif

// ----- hdl/lqa_pkg.sv -----
// types and constants for the link quality acceptance core
// no dependencies
`timescale 1ns / 1ps

package lqa_pkg;

   localparam int MAX_WINDOW = 256;
   localparam int MAX_ROUNDS = 8;

   localparam logic [1:0] CSR_WINDOW_SIZE   = 2'd0;
   localparam logic [1:0] CSR_ASYM_EXPONENT = 2'd1;

   typedef struct packed {
      logic [8:0] echo_count;
      logic [8:0] receive_count;
   } req_type;

   typedef struct packed {
      logic [7:0] neighbour_quality;
      logic [8:0] quality_power;
      logic [8:0] acceptance_value;
   } rsp_type;

endpackage

// ----- hdl/lqa_div.sv -----
// pipelined restoring divider, one quotient bit per stage
// the caller guarantees dividend >> QUO_W is below the divisor
`timescale 1ns / 1ps

module lqa_div #(
   parameter int NUM_W  = 17,
   parameter int DEN_W  = 9,
   parameter int QUO_W  = 17,
   parameter int SIDE_W = 1
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              in_valid,
   input  logic [NUM_W-1:0]  in_dividend,
   input  logic [DEN_W-1:0]  in_divisor,
   input  logic [SIDE_W-1:0] in_side,
   output logic              out_valid,
   output logic [QUO_W-1:0]  out_quotient,
   output logic [SIDE_W-1:0] out_side
);

   localparam int WORK_W = NUM_W + DEN_W;

   logic [WORK_W-1:0] work;
   logic              valid_ff [QUO_W];
   logic [DEN_W-1:0]  rem_ff   [QUO_W];
   logic [QUO_W-1:0]  bits_ff  [QUO_W];
   logic [DEN_W-1:0]  den_ff   [QUO_W];
   logic [SIDE_W-1:0] side_ff  [QUO_W];

   assign work = {{DEN_W{1'b0}}, in_dividend};

   for (genvar s = 0; s < QUO_W; s++) begin : g_step
      logic              prev_valid;
      logic [DEN_W-1:0]  prev_rem;
      logic [QUO_W-1:0]  prev_bits;
      logic [DEN_W-1:0]  prev_den;
      logic [SIDE_W-1:0] prev_side;
      logic [DEN_W:0]    rem2;
      logic [DEN_W:0]    diff;
      logic              ge;
      logic              valid_in;
      logic [DEN_W-1:0]  rem_in;
      logic [QUO_W-1:0]  bits_in;

      if (s == 0) begin : g_first
         assign prev_valid = in_valid;
         assign prev_rem   = work[QUO_W +: DEN_W];
         assign prev_bits  = in_dividend[QUO_W-1:0];
         assign prev_den   = in_divisor;
         assign prev_side  = in_side;
      end else begin : g_next
         assign prev_valid = valid_ff[s-1];
         assign prev_rem   = rem_ff[s-1];
         assign prev_bits  = bits_ff[s-1];
         assign prev_den   = den_ff[s-1];
         assign prev_side  = side_ff[s-1];
      end

      always_comb begin
         rem2     = {prev_rem, prev_bits[QUO_W-1]};
         diff     = rem2 - {1'b0, prev_den};
         ge       = (rem2 >= {1'b0, prev_den});
         rem_in   = ge ? diff[DEN_W-1:0] : rem2[DEN_W-1:0];
         bits_in  = {prev_bits[QUO_W-2:0], ge};
         valid_in = prev_valid;
      end

      always_ff @(posedge clock) begin
         if (reset) begin
            valid_ff[s] <= 1'b0;
         end else begin
            valid_ff[s] <= valid_in;
         end
         rem_ff[s]  <= rem_in;
         bits_ff[s] <= bits_in;
         den_ff[s]  <= prev_den;
         side_ff[s] <= prev_side;
      end
   end

   // final remainder is not needed, only the quotient
   assign out_valid    = valid_ff[QUO_W-1];
   assign out_quotient = bits_ff[QUO_W-1];
   assign out_side     = side_ff[QUO_W-1];

endmodule

// ----- hdl/link_quality_acceptance_core.sv -----
// top level of the link quality acceptance core
// depends on lqa_pkg and lqa_div
//
//   channel  ports                      handshake
//   request  req_*, start, busy         start && !busy
//   result   rsp_*, rsp_valid           one-cycle strobe, no back pressure
//   config   csr_*                      csr_valid && csr_ready
//
// one request per cycle, results in the order of the requests;
// the pipeline depth is set by the ratio divider (17 steps), eight power rounds
// (multiply plus 8 divide steps each) and the 9-step acceptance divider.
// reset clears pipeline valids and sets window 128, exponent 1.
// busy stays low and csr_ready stays high; nothing in the pipe ever stalls.
`timescale 1ns / 1ps

module link_quality_acceptance_core (
   input  logic             clock,
   input  logic             reset,
   input  logic             start,
   output logic             busy,
   input  lqa_pkg::req_type req_data,
   output logic             rsp_valid,
   output lqa_pkg::rsp_type rsp_data,
   input  logic             csr_valid,
   output logic             csr_ready,
   input  logic [1:0]       csr_index,
   input  logic [8:0]       csr_wdata
);

   import lqa_pkg::*;

   logic [8:0] window_ff;
   logic [2:0] exponent_ff;
   logic [8:0] w_eff;
   logic [7:0] w_m1;

   assign busy      = 1'b0;
   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         window_ff   <= 9'd128;
         exponent_ff <= 3'd1;
      end else if (csr_valid && csr_ready) begin
         case (csr_index)
            CSR_WINDOW_SIZE:   window_ff   <= csr_wdata;
            CSR_ASYM_EXPONENT: exponent_ff <= csr_wdata[2:0];
            default: ;
         endcase
      end
   end

   always_comb begin
      if (window_ff == 9'd0) begin
         w_eff = 9'd1;
      end else if ({23'd0, window_ff} > MAX_WINDOW) begin
         w_eff = 9'(MAX_WINDOW);
      end else begin
         w_eff = window_ff;
      end
      w_m1 = 8'(w_eff - 9'd1);
   end

   // stage a: w * echo, guarded divisor
   logic        a_valid_ff;
   logic [16:0] a_prod_ff;
   logic [8:0]  a_den_ff;
   logic        a_zero_ff;
   logic [8:0]  a_rcvd_ff;
   logic [17:0] a_prod_in;

   assign a_prod_in = w_eff * req_data.echo_count;

   always_ff @(posedge clock) begin
      if (reset) begin
         a_valid_ff <= 1'b0;
      end else begin
         a_valid_ff <= start && !busy;
      end
      a_prod_ff <= a_prod_in[16:0];
      a_den_ff  <= (req_data.receive_count == 9'd0) ? 9'd1 : req_data.receive_count;
      a_zero_ff <= (req_data.echo_count == 9'd0) || (req_data.receive_count == 9'd0);
      a_rcvd_ff <= req_data.receive_count;
   end

   logic        r_valid;
   logic [16:0] r_ratio;
   logic [9:0]  r_side;

   lqa_div #(.NUM_W(17), .DEN_W(9), .QUO_W(17), .SIDE_W(10)) u_ratio_div (
      .clock       (clock),
      .reset       (reset),
      .in_valid    (a_valid_ff),
      .in_dividend (a_prod_ff),
      .in_divisor  (a_den_ff),
      .in_side     ({a_zero_ff, a_rcvd_ff}),
      .out_valid   (r_valid),
      .out_quotient(r_ratio),
      .out_side    (r_side)
   );

   // stage b: quality with clamp
   logic        b_valid_ff;
   logic [7:0]  b_quality_ff;
   logic [8:0]  b_rcvd_ff;
   logic [7:0]  b_quality_in;
   logic [16:0] ratio_m1;

   always_comb begin
      ratio_m1 = r_ratio - 17'd1;
      if (r_side[9] || r_ratio == 17'd0) begin
         b_quality_in = 8'd0;
      end else if (ratio_m1 > {9'd0, w_m1}) begin
         b_quality_in = w_m1;
      end else begin
         b_quality_in = ratio_m1[7:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         b_valid_ff <= 1'b0;
      end else begin
         b_valid_ff <= r_valid;
      end
      b_quality_ff <= b_quality_in;
      b_rcvd_ff    <= r_side[8:0];
   end

   // power rounds: product register then divide by w
   logic       pw_valid   [MAX_ROUNDS+1];
   logic [8:0] pw_power   [MAX_ROUNDS+1];
   logic [7:0] pw_quality [MAX_ROUNDS+1];
   logic [8:0] pw_rcvd    [MAX_ROUNDS+1];

   assign pw_valid[0]   = b_valid_ff;
   assign pw_power[0]   = w_eff;
   assign pw_quality[0] = b_quality_ff;
   assign pw_rcvd[0]    = b_rcvd_ff;

   for (genvar r = 0; r < MAX_ROUNDS; r++) begin : g_round
      logic        m_valid_ff;
      logic [15:0] m_prod_ff;
      logic [25:0] m_side_ff;
      logic [16:0] m_prod_in;
      logic        d_valid;
      logic [7:0]  d_quo;
      logic [25:0] d_side;

      assign m_prod_in = pw_power[r] * pw_quality[r];

      always_ff @(posedge clock) begin
         if (reset) begin
            m_valid_ff <= 1'b0;
         end else begin
            m_valid_ff <= pw_valid[r];
         end
         m_prod_ff <= m_prod_in[15:0];
         m_side_ff <= {pw_power[r], pw_quality[r], pw_rcvd[r]};
      end

      lqa_div #(.NUM_W(16), .DEN_W(9), .QUO_W(8), .SIDE_W(26)) u_pow_div (
         .clock       (clock),
         .reset       (reset),
         .in_valid    (m_valid_ff),
         .in_dividend (m_prod_ff),
         .in_divisor  (w_eff),
         .in_side     (m_side_ff),
         .out_valid   (d_valid),
         .out_quotient(d_quo),
         .out_side    (d_side)
      );

      // rounds past the exponent leave the power as it was
      assign pw_valid[r+1]   = d_valid;
      assign pw_power[r+1]   = (r <= int'(exponent_ff)) ? {1'b0, d_quo} : d_side[25:17];
      assign pw_quality[r+1] = d_side[16:9];
      assign pw_rcvd[r+1]    = d_side[8:0];
   end

   // acceptance: power * rcvd / w
   logic        c_valid_ff;
   logic [16:0] c_prod_ff;
   logic [16:0] c_side_ff;
   logic [17:0] c_prod_in;
   logic        e_valid;
   logic [8:0]  e_quo;
   logic [16:0] e_side;

   assign c_prod_in = pw_power[MAX_ROUNDS] * pw_rcvd[MAX_ROUNDS];

   always_ff @(posedge clock) begin
      if (reset) begin
         c_valid_ff <= 1'b0;
      end else begin
         c_valid_ff <= pw_valid[MAX_ROUNDS];
      end
      c_prod_ff <= c_prod_in[16:0];
      c_side_ff <= {pw_quality[MAX_ROUNDS], pw_power[MAX_ROUNDS]};
   end

   lqa_div #(.NUM_W(17), .DEN_W(9), .QUO_W(9), .SIDE_W(17)) u_acc_div (
      .clock       (clock),
      .reset       (reset),
      .in_valid    (c_valid_ff),
      .in_dividend (c_prod_ff),
      .in_divisor  (w_eff),
      .in_side     (c_side_ff),
      .out_valid   (e_valid),
      .out_quotient(e_quo),
      .out_side    (e_side)
   );

   logic    rsp_valid_ff;
   rsp_type rsp_data_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= e_valid;
      end
      rsp_data_ff.neighbour_quality <= e_side[16:9];
      rsp_data_ff.quality_power     <= e_side[8:0];
      rsp_data_ff.acceptance_value  <= e_quo;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

endmodule

// ----- hdl/lqa_checker.sv -----
// port-level checks for the link quality acceptance core, bound to the top level
// depends on lqa_pkg and the assertion macro header
`timescale 1ns / 1ps
`include "link_quality_acceptance_core_assert.svh"

module lqa_checker (
   input logic             clock,
   input logic             reset,
   input logic             start,
   input logic             busy,
   input lqa_pkg::req_type req_data,
   input logic             rsp_valid,
   input lqa_pkg::rsp_type rsp_data,
   input logic             csr_valid,
   input logic             csr_ready,
   input logic [1:0]       csr_index,
   input logic [8:0]       csr_wdata
);

   import lqa_pkg::*;

   `LQA_ASSERT(a_no_rsp_after_reset, $past(reset) |-> !rsp_valid, "result right after reset")
   `LQA_ASSERT(a_zero_quality, rsp_valid && rsp_data.neighbour_quality == 8'd0 |-> rsp_data.quality_power == 9'd0 && rsp_data.acceptance_value == 9'd0, "nonzero power from zero quality")
   `LQA_ASSERT(a_power_bound, rsp_valid |-> rsp_data.quality_power <= {1'b0, rsp_data.neighbour_quality}, "power above quality")
   `LQA_ASSERT(a_always_ready, !busy && csr_ready, "request or config side held off")

endmodule

bind link_quality_acceptance_core lqa_checker u_lqa_checker (.*);

// ----- tb/tb_link_quality_acceptance_core.sv -----
// testbench for the link quality acceptance core: directed and random requests
// with in-order prediction and field-by-field checking; depends on lqa_pkg
`timescale 1ns / 1ps

module tb_link_quality_acceptance_core;
   import lqa_pkg::*;

   localparam int PIPE_DEPTH  = 102;
   localparam int CYCLE_LIMIT = 200000;

   logic    clock = 1'b0;
   logic    reset = 1'b1;
   logic    start = 1'b0;
   logic    busy;
   req_type req_data = '0;
   logic    rsp_valid;
   rsp_type rsp_data;
   logic    csr_valid = 1'b0;
   logic    csr_ready;
   logic [1:0] csr_index = CSR_WINDOW_SIZE;
   logic [8:0] csr_wdata = '0;

   link_quality_acceptance_core dut (.*);

   always begin
      #2 clock = 1'b1;
      #2 clock = 1'b0;
   end

   // predictor copy of the registers
   logic [8:0] window_reg = 9'd128;
   logic [2:0] exponent_reg = 3'd1;

   req_type pending_reqs[$];
   rsp_type expected_rsps[$];
   int      idle_pct = 38;
   int      error_count = 0;
   int      cycle_count = 0;

   function automatic rsp_type predict_acceptance(req_type r);
      longint unsigned w, ratio, quality, power;
      rsp_type o;
      w = window_reg;
      if (w == 0) w = 1;
      if (w > MAX_WINDOW) w = MAX_WINDOW;
      quality = 0;
      if (r.echo_count != 0 && r.receive_count != 0) begin
         ratio = (w * r.echo_count) / r.receive_count;
         quality = (ratio == 0) ? 0 : ratio - 1;
         if (quality > w - 1) quality = w - 1;
      end
      power = w;
      for (int k = 0; k < MAX_ROUNDS; k++)
         if (k <= exponent_reg) power = (power * quality) / w;
      o.neighbour_quality = quality[7:0];
      o.quality_power     = power[8:0];
      o.acceptance_value  = ((power * r.receive_count) / w) & 9'h1FF;
      return o;
   endfunction

   // driver
   always @(posedge clock) begin
      if (reset) begin
         start <= 1'b0;
      end else begin
         if (start && !busy) begin
            expected_rsps.push_back(predict_acceptance(req_data));
            void'(pending_reqs.pop_front());
         end
         // the accepted request is already popped, so the next one is at the front
         if ((!start || !busy) && pending_reqs.size() != 0
             && $urandom_range(99) >= idle_pct) begin
            start    <= 1'b1;
            req_data <= pending_reqs[0];
         end else if (!start || !busy) begin
            start <= 1'b0;
         end
      end
   end

   // monitor
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (!reset && rsp_valid) begin
         if (expected_rsps.size() == 0) begin
            $error("result with nothing expected");
            error_count = error_count + 1;
         end else begin
            rsp_type e;
            e = expected_rsps.pop_front();
            if (rsp_data.neighbour_quality !== e.neighbour_quality) begin
               $error("neighbour_quality exp %0d got %0d", e.neighbour_quality,
                      rsp_data.neighbour_quality);
               error_count = error_count + 1;
            end
            if (rsp_data.quality_power !== e.quality_power) begin
               $error("quality_power exp %0d got %0d", e.quality_power,
                      rsp_data.quality_power);
               error_count = error_count + 1;
            end
            if (rsp_data.acceptance_value !== e.acceptance_value) begin
               $error("acceptance_value exp %0d got %0d", e.acceptance_value,
                      rsp_data.acceptance_value);
               error_count = error_count + 1;
            end
         end
      end
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("TB_ERROR");
         $finish;
      end
   end

   task automatic queue_request(int echo, int rcvd);
      req_type r;
      r.echo_count    = echo[8:0];
      r.receive_count = rcvd[8:0];
      pending_reqs.push_back(r);
   endtask

   task automatic drain;
      while (pending_reqs.size() != 0 || start || expected_rsps.size() != 0)
         @(posedge clock);
      repeat (PIPE_DEPTH + 5) @(posedge clock);
   endtask

   task automatic write_csr(logic [1:0] idx, logic [8:0] val);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_wdata <= val;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      csr_valid <= 1'b0;
      if (idx == CSR_WINDOW_SIZE) window_reg = val;
      else if (idx == CSR_ASYM_EXPONENT) exponent_reg = val[2:0];
   endtask

   task automatic random_phase(int n);
      int w;
      w = (window_reg == 0) ? 1 : (window_reg > MAX_WINDOW ? MAX_WINDOW : window_reg);
      for (int i = 0; i < n; i++) begin
         case ($urandom_range(9))
            0: queue_request($urandom_range(511), $urandom_range(511));
            1: queue_request(0, $urandom_range(511));
            2: queue_request($urandom_range(511), 0);
            default: queue_request($urandom_range(w), $urandom_range(w));
         endcase
      end
   endtask

   initial begin
      repeat (10) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // directed: reset settings, extremes, zero counts, clamp cases
      queue_request(0, 0);
      queue_request(0, 256);
      queue_request(256, 0);
      queue_request(1, 256);
      queue_request(128, 128);
      queue_request(256, 1);
      queue_request(511, 511);
      queue_request(511, 1);
      queue_request(1, 511);
      queue_request(100, 128);
      queue_request(64, 128);
      queue_request(129, 128);
      queue_request(9'h155, 9'h0AA);
      queue_request(9'h0AA, 9'h155);
      drain();

      write_csr(CSR_WINDOW_SIZE, 9'd256);
      write_csr(CSR_ASYM_EXPONENT, 9'd0);
      queue_request(256, 256);
      queue_request(255, 256);
      queue_request(511, 256);
      drain();
      write_csr(CSR_WINDOW_SIZE, 9'd0);
      write_csr(CSR_ASYM_EXPONENT, 9'd7);
      queue_request(5, 3);
      queue_request(1, 1);
      drain();
      write_csr(CSR_WINDOW_SIZE, 9'd511);
      queue_request(256, 200);
      queue_request(511, 300);
      drain();

      // random phases across settings; no idling in one phase
      for (int p = 0; p < 8; p++) begin
         case (p)
            0: write_csr(CSR_WINDOW_SIZE, 9'd1);
            1: write_csr(CSR_WINDOW_SIZE, 9'd256);
            2: write_csr(CSR_WINDOW_SIZE, 9'd128);
            default: write_csr(CSR_WINDOW_SIZE, 9'($urandom_range(511)));
         endcase
         write_csr(CSR_ASYM_EXPONENT, 9'((p < 2) ? 7 * p[0] : $urandom_range(7)));
         idle_pct = (p == 3) ? 0 : 38;
         random_phase(65);
         drain();
      end

      if (error_count == 0 && expected_rsps.size() == 0) begin
         $display("TB_OK");
      end else begin
         $display("TB_ERROR");
      end
      $finish;
   end

endmodule
